// ===== design/mbrf_pkg.sv =====
// mbrf_pkg: shared types and codes for the multichannel burst ring FIFO.
// No dependencies; used by the core, the sample store and the port checker.
package mbrf_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH_BEGIN = 2'd0,
      CMD_PUSH_ELEM  = 2'd1,
      CMD_POP        = 2'd2,
      CMD_UNUSED     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic REG_CHANNELS = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   localparam int CFG_W   = 9;   // widest register
   localparam int COUNT_W = 7;
   localparam int WORD_W  = 32;
   localparam int CNT_W   = 9;   // used/free report width

   typedef enum logic {
      FSM_IDLE,
      FSM_POP
   } fsm_type;

endpackage

// ===== design/mbrf_store.sv =====
// mbrf_store: single-port-write, single-port-read word memory for the ring.
// Read data is registered and holds while no read is issued. Uses mbrf_pkg.
module mbrf_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [mbrf_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [mbrf_pkg::WORD_W-1:0] rd_data
);

   logic [mbrf_pkg::WORD_W-1:0] store_ff [DEPTH];
   logic [mbrf_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/multichannel_burst_ring_fifo_core.sv =====
// Multichannel burst ring FIFO core.
// Input channel req_*: one command word per handshake (push_begin, push_element, pop).
// Result channel rsp_*: status, popped word, last marker and used/free sample counts.
// csr_*: write-only port; index 0 sets channels per sample, index 1 the capacity in
// samples. Either write empties the ring (stored words are kept but unreachable).
// push_begin, push_element, refused pops and invalid commands give one result word,
// registered, in the cycle after acceptance; a new command can be taken every cycle
// while the result register is free or being drained.
// An accepted pop of n samples gives n*channels words: the first once the pop state is
// entered and its first read is registered, then one per cycle while rsp_stall is low,
// each read from the sample memory's registered read port. The command channel is
// stalled until the last read is issued.
// When rsp_stall is high and a result is held, that word holds and no further read is
// issued; the command channel stalls while a result waits.
// Reset (synchronous) empties the ring, closes any open burst, restores channels 1
// and capacity 256, and drops any pending result. No clearing pass is needed.
module multichannel_burst_ring_fifo_core #(
   parameter int MAX_SAMPLES     = 256,
   parameter int MAX_CHANNELS    = 8,
   parameter int MAX_BURST_ELEMS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [mbrf_pkg::COUNT_W-1:0]      req_count,
   input  logic [mbrf_pkg::WORD_W-1:0]       req_data_in,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [mbrf_pkg::WORD_W-1:0]       rsp_data_out,
   output logic                              rsp_last,
   output logic [mbrf_pkg::CNT_W-1:0]        rsp_used_count,
   output logic [mbrf_pkg::CNT_W-1:0]        rsp_free_count,
   // configuration
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [mbrf_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int DEPTH = MAX_SAMPLES * MAX_CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(DEPTH + 1);
   localparam int CAP_W = $clog2(MAX_SAMPLES + 1);
   localparam int ECH_W = $clog2(MAX_CHANNELS + 1);
   localparam int TW    = mbrf_pkg::COUNT_W + ECH_W;
   localparam int SW    = ((AW > TW) ? AW : TW) + 1;
   localparam int CMP_W = ((CAP_W > mbrf_pkg::COUNT_W) ? CAP_W : mbrf_pkg::COUNT_W) + 1;
   localparam int BW    = mbrf_pkg::COUNT_W;

   // pos < ring and n <= ring, so one conditional subtract wraps
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                              input logic [TW-1:0] n,
                                              input logic [RW-1:0] ring);
      logic [SW-1:0] sum;
      sum = SW'(pos) + SW'(n);
      if (sum >= SW'(ring)) begin
         return AW'(sum - SW'(ring));
      end
      return AW'(sum);
   endfunction

   // configuration
   logic [3:0]       channels_ff, channels_in;
   logic [8:0]       capacity_ff, capacity_in;
   logic [ECH_W-1:0] eff_ch;
   logic [CAP_W-1:0] eff_cap;
   logic [RW-1:0]    ring;

   // ring state
   mbrf_pkg::fsm_type state_ff, state_in;
   logic [AW-1:0]    write_pos_ff, write_pos_in;
   logic [AW-1:0]    read_pos_ff, read_pos_in;
   logic [CAP_W-1:0] stored_ff, stored_in;
   logic             burst_open_ff, burst_open_in;
   logic [BW-1:0]    burst_left_ff, burst_left_in;
   logic [BW-1:0]    burst_samples_ff, burst_samples_in;
   logic [AW-1:0]    burst_wpos_ff, burst_wpos_in;
   logic [AW-1:0]    pop_addr_ff, pop_addr_in;
   logic [BW-1:0]    pop_left_ff, pop_left_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic             out_sel_mem_ff, out_sel_mem_in;
   logic [1:0]       out_status_ff, out_status_in;
   logic             out_last_ff, out_last_in;
   logic [mbrf_pkg::CNT_W-1:0] out_used_ff, out_used_in;
   logic [mbrf_pkg::CNT_W-1:0] out_free_ff, out_free_in;

   // datapath
   logic             slot_free, accept, rd_en, pop_start;
   logic [TW-1:0]    total;
   logic             bad_size;
   logic [CAP_W-1:0] free_now;
   logic             no_room, short_data;
   logic             wr_en;
   logic [mbrf_pkg::WORD_W-1:0] mem_rd_data;

   always_comb begin
      if (channels_ff == 4'd0) begin
         eff_ch = ECH_W'(1);
      end else if (int'(channels_ff) > MAX_CHANNELS) begin
         eff_ch = ECH_W'(MAX_CHANNELS);
      end else begin
         eff_ch = ECH_W'(channels_ff);
      end
      if (capacity_ff == 9'd0) begin
         eff_cap = CAP_W'(1);
      end else if (int'(capacity_ff) > MAX_SAMPLES) begin
         eff_cap = CAP_W'(MAX_SAMPLES);
      end else begin
         eff_cap = CAP_W'(capacity_ff);
      end
   end

   assign ring       = RW'(RW'(eff_cap) * RW'(eff_ch));
   assign total      = TW'(TW'(req_count) * TW'(eff_ch));
   assign bad_size   = (req_count == '0) || (int'(total) > MAX_BURST_ELEMS)
                       || (int'(ring) < int'(total));
   assign free_now   = eff_cap - stored_ff;
   assign no_room    = CMP_W'(free_now) < CMP_W'(req_count);
   assign short_data = CMP_W'(stored_ff) < CMP_W'(req_count);

   assign slot_free  = !out_valid_ff || !rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign pop_start  = accept && (req_cmd == mbrf_pkg::CMD_POP) && !bad_size && !short_data;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbrf_pkg::FSM_IDLE: begin
            if (pop_start) begin
               state_in = mbrf_pkg::FSM_POP;
            end
         end
         mbrf_pkg::FSM_POP: begin
            if (rd_en && pop_left_ff == BW'(1)) begin
               state_in = mbrf_pkg::FSM_IDLE;
            end
         end
         default: state_in = mbrf_pkg::FSM_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      case (state_ff)
         mbrf_pkg::FSM_IDLE: req_stall = !slot_free;
         mbrf_pkg::FSM_POP:  rd_en     = slot_free;
         default: begin
            req_stall = 1'b1;
            rd_en     = 1'b0;
         end
      endcase
   end

   // ring bookkeeping and result word
   always_comb begin
      channels_in      = channels_ff;
      capacity_in      = capacity_ff;
      write_pos_in     = write_pos_ff;
      read_pos_in      = read_pos_ff;
      stored_in        = stored_ff;
      burst_open_in    = burst_open_ff;
      burst_left_in    = burst_left_ff;
      burst_samples_in = burst_samples_ff;
      burst_wpos_in    = burst_wpos_ff;
      pop_addr_in      = pop_addr_ff;
      pop_left_in      = pop_left_ff;
      wr_en            = 1'b0;
      out_valid_in     = out_valid_ff && rsp_stall;
      out_sel_mem_in   = out_sel_mem_ff;
      out_status_in    = out_status_ff;
      out_last_in      = out_last_ff;

      if (csr_we) begin
         case (csr_index)
            mbrf_pkg::REG_CHANNELS: channels_in = csr_wdata[3:0];
            mbrf_pkg::REG_CAPACITY: capacity_in = csr_wdata;
            default: channels_in = channels_ff;
         endcase
         write_pos_in     = '0;
         read_pos_in      = '0;
         stored_in        = '0;
         burst_open_in    = 1'b0;
         burst_left_in    = '0;
         burst_samples_in = '0;
      end else if (rd_en) begin
         pop_addr_in    = ring_add(pop_addr_ff, TW'(1), ring);
         pop_left_in    = pop_left_ff - BW'(1);
         out_valid_in   = 1'b1;
         out_sel_mem_in = 1'b1;
         out_status_in  = mbrf_pkg::ST_OK;
         out_last_in    = (pop_left_ff == BW'(1));
      end else if (accept) begin
         out_valid_in   = 1'b1;
         out_sel_mem_in = 1'b0;
         out_last_in    = 1'b1;
         out_status_in  = mbrf_pkg::ST_INVALID;
         case (req_cmd)
            mbrf_pkg::CMD_PUSH_BEGIN: begin
               burst_open_in    = 1'b0;
               burst_left_in    = '0;
               burst_samples_in = '0;
               if (bad_size) begin
                  out_status_in = mbrf_pkg::ST_INVALID;
               end else if (no_room) begin
                  out_status_in = mbrf_pkg::ST_NO_ROOM;
               end else begin
                  out_status_in    = mbrf_pkg::ST_OK;
                  burst_open_in    = 1'b1;
                  burst_samples_in = req_count;
                  burst_left_in    = BW'(total);
                  burst_wpos_in    = write_pos_ff;
               end
            end
            mbrf_pkg::CMD_PUSH_ELEM: begin
               if (burst_open_ff) begin
                  out_status_in = mbrf_pkg::ST_OK;
                  wr_en         = 1'b1;
                  burst_wpos_in = ring_add(burst_wpos_ff, TW'(1), ring);
                  burst_left_in = burst_left_ff - BW'(1);
                  if (burst_left_ff == BW'(1)) begin
                     // last word of the burst: commit it
                     write_pos_in     = ring_add(burst_wpos_ff, TW'(1), ring);
                     stored_in        = CAP_W'(stored_ff + CAP_W'(burst_samples_ff));
                     burst_open_in    = 1'b0;
                     burst_samples_in = '0;
                  end
               end
            end
            mbrf_pkg::CMD_POP: begin
               if (bad_size) begin
                  out_status_in = mbrf_pkg::ST_INVALID;
               end else if (short_data) begin
                  out_status_in = mbrf_pkg::ST_NO_ROOM;
               end else begin
                  // words follow from the read engine
                  out_valid_in = 1'b0;
                  stored_in    = stored_ff - CAP_W'(req_count);
                  read_pos_in  = ring_add(read_pos_ff, total, ring);
                  pop_addr_in  = read_pos_ff;
                  pop_left_in  = BW'(total);
               end
            end
            default: out_status_in = mbrf_pkg::ST_INVALID;
         endcase
      end
   end

   assign out_used_in = mbrf_pkg::CNT_W'(stored_in);
   assign out_free_in = mbrf_pkg::CNT_W'(eff_cap - stored_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mbrf_pkg::FSM_IDLE;
         channels_ff      <= 4'd1;
         capacity_ff      <= 9'd256;
         write_pos_ff     <= '0;
         read_pos_ff      <= '0;
         stored_ff        <= '0;
         burst_open_ff    <= 1'b0;
         burst_left_ff    <= '0;
         burst_samples_ff <= '0;
         pop_left_ff      <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         channels_ff      <= channels_in;
         capacity_ff      <= capacity_in;
         write_pos_ff     <= write_pos_in;
         read_pos_ff      <= read_pos_in;
         stored_ff        <= stored_in;
         burst_open_ff    <= burst_open_in;
         burst_left_ff    <= burst_left_in;
         burst_samples_ff <= burst_samples_in;
         pop_left_ff      <= pop_left_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_wpos_ff  <= burst_wpos_in;
      pop_addr_ff    <= pop_addr_in;
      out_sel_mem_ff <= out_sel_mem_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
      if (out_valid_in || !out_valid_ff) begin
         out_used_ff <= out_used_in;
         out_free_ff <= out_free_in;
      end
   end

   mbrf_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (burst_wpos_ff),
      .wr_data (req_data_in),
      .rd_en   (rd_en),
      .rd_addr (pop_addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_data_out   = out_sel_mem_ff ? mem_rd_data : '0;
   assign rsp_last       = out_last_ff;
   assign rsp_used_count = out_used_ff;
   assign rsp_free_count = out_free_ff;

endmodule

// ===== design/mbrf_checker.sv =====
// mbrf_checker: port-level checks of the ring FIFO core, bound to its top level.
// Depends on mbrf_pkg for status codes.
module mbrf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [mbrf_pkg::WORD_W-1:0]  rsp_data_out,
   input logic                         rsp_last
);

   // a waiting word is not dropped
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped under stall");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data_out) && $stable(rsp_last))
      else $error("stalled result word changed");

   // a refused or invalid command gives one bare word
   a_reject_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mbrf_pkg::ST_OK |-> rsp_last && rsp_data_out == '0)
      else $error("rejected command gave a data word or a burst");

   // only pop words can be non-final, and they are always accepted ones
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == mbrf_pkg::ST_OK)
      else $error("non-final word carries a failure status");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

bind multichannel_burst_ring_fifo_core mbrf_checker u_mbrf_checker (.*);

// ===== verif/multichannel_burst_ring_fifo_core_tb.sv =====
// Self-checking testbench for multichannel_burst_ring_fifo_core: burst pushes, pops and
// refusals under random idling, with an in-bench ring predictor and an in-order result check.
// Depends on design/mbrf_pkg.sv and design/multichannel_burst_ring_fifo_core.sv.
module multichannel_burst_ring_fifo_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbrf_pkg::*;

   localparam int RING_MAX  = 256;
   localparam int CH_MAX    = 8;
   localparam int BURST_MAX = 64;

   typedef struct packed {
      cmd_type              cmd;
      logic [COUNT_W-1:0]   count;
      logic [WORD_W-1:0]    data;
   } fifo_cmd_type;

   typedef struct packed {
      status_type           status;
      logic [WORD_W-1:0]    word;
      logic                 last;
      logic [CNT_W-1:0]     used;
      logic [CNT_W-1:0]     free;
   } fifo_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_cmd = '0;
   logic [COUNT_W-1:0]   req_count = '0;
   logic [WORD_W-1:0]    req_data_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [WORD_W-1:0]    rsp_data_out;
   logic                 rsp_last;
   logic [CNT_W-1:0]     rsp_used_count;
   logic [CNT_W-1:0]     rsp_free_count;
   logic                 csr_we = 1'b0;
   logic                 csr_index = 1'b0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   multichannel_burst_ring_fifo_core #(
      .MAX_SAMPLES     (RING_MAX),
      .MAX_CHANNELS    (CH_MAX),
      .MAX_BURST_ELEMS (BURST_MAX)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_count      (req_count),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ring predictor state
   logic [WORD_W-1:0]    ring_mem [RING_MAX*CH_MAX];
   logic [3:0]           chan_reg = 4'd1;
   logic [8:0]           cap_reg = 9'd256;
   int unsigned          wr_pos = 0;
   int unsigned          rd_pos = 0;
   int unsigned          used_samples = 0;
   bit                   burst_active = 1'b0;
   int unsigned          burst_left = 0;
   int unsigned          burst_n = 0;

   fifo_cmd_type         cmd_queue[$];
   fifo_result_type      awaited_results[$];
   fifo_cmd_type         cur_cmd = '0;
   bit                   driving = 1'b0;
   int unsigned          gap_left = 0;
   int unsigned          stall_left = 0;
   int unsigned          snd_level = 0;
   int unsigned          rcv_level = 0;
   int unsigned          plan_used = 0;
   int unsigned          items_sent = 0;
   int unsigned          results_seen = 0;
   int unsigned          mismatches = 0;
   int unsigned          settings_used = 0;

   function automatic int unsigned eff_chans();
      if (chan_reg == 0) return 1;
      if (chan_reg > CH_MAX) return CH_MAX;
      return chan_reg;
   endfunction

   function automatic int unsigned eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > RING_MAX) return RING_MAX;
      return cap_reg;
   endfunction

   function automatic int unsigned ring_words();
      return eff_cap() * eff_chans();
   endfunction

   function automatic int unsigned wrap_add(input int unsigned pos, input int unsigned n);
      int unsigned s;
      s = pos + n;
      return (s >= ring_words()) ? s - ring_words() : s;
   endfunction

   function automatic bit size_bad(input int unsigned n);
      int unsigned words;
      words = n * eff_chans();
      return n == 0 || words > ring_words() || words > BURST_MAX;
   endfunction

   function automatic void note_result(input status_type st, input logic [WORD_W-1:0] w,
                                       input logic lst);
      fifo_result_type r;
      r.status = st;
      r.word   = w;
      r.last   = lst;
      r.used   = CNT_W'(used_samples);
      r.free   = CNT_W'(eff_cap() - used_samples);
      awaited_results.push_back(r);
   endfunction

   function automatic void predict_results(input fifo_cmd_type c);
      int unsigned ch, total, pos, i;
      ch = eff_chans();
      case (c.cmd)
         CMD_PUSH_BEGIN: begin
            // a new burst request always drops whatever burst was open
            burst_active = 1'b0;
            burst_left   = 0;
            burst_n      = 0;
            if (size_bad(c.count)) note_result(ST_INVALID, '0, 1'b1);
            else if (eff_cap() - used_samples < c.count) note_result(ST_NO_ROOM, '0, 1'b1);
            else begin
               burst_active = 1'b1;
               burst_n      = c.count;
               burst_left   = c.count * ch;
               note_result(ST_OK, '0, 1'b1);
            end
         end
         CMD_PUSH_ELEM: begin
            if (!burst_active) note_result(ST_INVALID, '0, 1'b1);
            else begin
               total = burst_n * ch;
               pos = wrap_add(wr_pos, total - burst_left);
               ring_mem[pos] = c.data;
               burst_left--;
               if (burst_left == 0) begin
                  wr_pos = wrap_add(wr_pos, total);
                  used_samples += burst_n;
                  burst_active = 1'b0;
                  burst_n = 0;
               end
               note_result(ST_OK, '0, 1'b1);
            end
         end
         CMD_POP: begin
            if (size_bad(c.count)) note_result(ST_INVALID, '0, 1'b1);
            else if (used_samples < c.count) note_result(ST_NO_ROOM, '0, 1'b1);
            else begin
               total = c.count * ch;
               pos = rd_pos;
               used_samples -= c.count;
               rd_pos = wrap_add(rd_pos, total);
               for (i = 0; i < total; i++) begin
                  note_result(ST_OK, ring_mem[pos], i + 1 == total);
                  pos = wrap_add(pos, 1);
               end
            end
         end
         default: note_result(ST_INVALID, '0, 1'b1);
      endcase
   endfunction

   function automatic string show_result(input fifo_result_type r);
      return $sformatf("status %0d word %h last %b used %0d free %0d",
                       r.status, r.word, r.last, r.used, r.free);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 50) $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // mostly short idles, now and then a long one
   function automatic int unsigned pick_idle();
      return ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(30, 8);
   endfunction

   function automatic int unsigned pick_level();
      int unsigned r;
      r = $urandom_range(2);
      return (r == 0) ? 0 : (r == 1) ? 10 : 25;
   endfunction

   // command driver: the predictor runs on each word the block takes
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         driving = 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_results(cur_cmd);
            items_sent++;
            driving = 1'b0;
         end
         if (!driving) begin
            if (gap_left > 0) gap_left--;
            else if (cmd_queue.size() != 0) begin
               cur_cmd = cmd_queue.pop_front();
               driving = 1'b1;
               gap_left = (snd_level != 0 && $urandom_range(99) < snd_level) ? pick_idle() : 0;
            end
         end
         req_valid   <= driving;
         req_cmd     <= cur_cmd.cmd;
         req_count   <= cur_cmd.count;
         req_data_in <= cur_cmd.data;
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin : result_monitor
      fifo_result_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.word   = rsp_data_out;
            got.last   = rsp_last;
            got.used   = rsp_used_count;
            got.free   = rsp_free_count;
            results_seen++;
            if (awaited_results.size() == 0)
               report_mismatch({"unexpected word: ", show_result(got)});
            else begin
               want = awaited_results.pop_front();
               if (got !== want)
                  report_mismatch({"got ", show_result(got), " / want ", show_result(want)});
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rcv_level != 0 && $urandom_range(99) < rcv_level) begin
            stall_left = pick_idle() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_cmd(input cmd_type c, input logic [COUNT_W-1:0] n,
                            input logic [WORD_W-1:0] d);
      fifo_cmd_type w;
      w.cmd   = c;
      w.count = n;
      w.data  = d;
      cmd_queue.push_back(w);
   endtask

   // gives up once results stop arriving for a long while
   task automatic wait_drained();
      int unsigned quiet, seen;
      quiet = 0;
      while ((cmd_queue.size() != 0 || driving || awaited_results.size() != 0)
             && quiet < 5000) begin
         seen = results_seen;
         @(negedge clock);
         quiet = (results_seen == seen) ? quiet + 1 : 0;
      end
   endtask

   // only ever called with the block idle; either write empties the ring
   task automatic write_csr(input logic idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_CHANNELS) chan_reg = value[3:0];
      else cap_reg = value;
      wr_pos = 0;
      rd_pos = 0;
      used_samples = 0;
      burst_active = 1'b0;
      burst_left = 0;
      burst_n = 0;
      plan_used = 0;
      settings_used++;
   endtask

   // mostly complete bursts and legal pops, with noise, refusals and cut-short bursts
   task automatic gen_traffic(input int unsigned n_items);
      int unsigned ch, cap, maxn, n, k, made, roll, lim, room, budget;
      cmd_type kind;
      ch = eff_chans();
      cap = eff_cap();
      maxn = (BURST_MAX / ch < cap) ? BURST_MAX / ch : cap;
      made = 0;
      while (made < n_items) begin
         roll = $urandom_range(99);
         room = cap - plan_used;
         // bursts are sized to the words still to be made
         budget = (n_items - made - 1) / ch;
         if (budget == 0) budget = 1;
         if (budget > maxn) budget = maxn;
         if (roll < 12) begin
            queue_cmd(cmd_type'($urandom_range(3)), COUNT_W'($urandom), $urandom);
            made++;
         end else if (roll < 20) begin
            if ($urandom_range(1)) begin
               kind = CMD_PUSH_BEGIN;
               lim = room;
            end else begin
               kind = CMD_POP;
               lim = plan_used;
            end
            if (lim > maxn) lim = maxn;
            if (lim < maxn && $urandom_range(1)) n = $urandom_range(maxn, lim + 1);
            else n = $urandom_range(127, lim + 1);
            queue_cmd(kind, COUNT_W'(n), $urandom);
            made++;
         end else if (roll < 28 && room != 0) begin
            // burst abandoned part way through; nothing gets committed
            n = $urandom_range((room < budget) ? room : budget, 1);
            k = $urandom_range(n * ch - 1);
            queue_cmd(CMD_PUSH_BEGIN, COUNT_W'(n), $urandom);
            repeat (k) queue_cmd(CMD_PUSH_ELEM, COUNT_W'($urandom), $urandom);
            queue_cmd(CMD_PUSH_BEGIN, 0, $urandom);
            made += k + 2;
         end else if (room != 0 && (plan_used == 0 || $urandom_range(1))) begin
            n = $urandom_range((room < budget) ? room : budget, 1);
            queue_cmd(CMD_PUSH_BEGIN, COUNT_W'(n), $urandom);
            for (k = 0; k < n * ch; k++)
               queue_cmd(CMD_PUSH_ELEM, COUNT_W'($urandom), $urandom);
            plan_used += n;
            made += 1 + n * ch;
         end else begin
            n = $urandom_range((plan_used < maxn) ? plan_used : maxn, 1);
            queue_cmd(CMD_POP, COUNT_W'(n), $urandom);
            plan_used -= n;
            made++;
         end
      end
   endtask

   // sender pauses for a full drain half way through every setting
   task automatic run_phase(input logic [3:0] ch_code, input logic [CFG_W-1:0] cap_code,
                            input int unsigned n_items, input bit calm);
      wait_drained();
      write_csr(REG_CHANNELS, {5'($urandom), ch_code});
      write_csr(REG_CAPACITY, cap_code);
      @(negedge clock);
      snd_level = calm ? 0 : pick_level();
      rcv_level = calm ? 0 : pick_level();
      gen_traffic(n_items / 2);
      wait_drained();
      snd_level = calm ? 0 : pick_level();
      rcv_level = calm ? 0 : pick_level();
      gen_traffic(n_items - n_items / 2);
   endtask

   initial begin : stimulus
      int unsigned k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // two words per sample, three samples: six-word ring
      write_csr(REG_CHANNELS, 9'd2);
      write_csr(REG_CAPACITY, 9'd3);
      @(negedge clock);
      snd_level = 20;
      rcv_level = 20;
      queue_cmd(CMD_POP, 1, '0);                     // empty ring
      queue_cmd(CMD_PUSH_ELEM, 0, 32'hffff_ffff);     // no burst open
      queue_cmd(CMD_UNUSED, 127, 32'hffff_ffff);
      queue_cmd(CMD_PUSH_BEGIN, 0, '0);
      queue_cmd(CMD_PUSH_BEGIN, 127, '0);
      queue_cmd(CMD_PUSH_BEGIN, 4, '0);               // more than the ring holds
      queue_cmd(CMD_PUSH_BEGIN, 2, '0);
      queue_cmd(CMD_PUSH_ELEM, 0, 32'h1111_1111);     // dropped by the next begin
      queue_cmd(CMD_PUSH_BEGIN, 1, '0);
      queue_cmd(CMD_PUSH_ELEM, 0, 32'h0000_0000);
      queue_cmd(CMD_PUSH_ELEM, 127, 32'hffff_ffff);
      queue_cmd(CMD_PUSH_BEGIN, 3, '0);               // only two samples free
      queue_cmd(CMD_PUSH_BEGIN, 2, '0);
      queue_cmd(CMD_PUSH_ELEM, 0, 32'ha5a5_a5a5);
      queue_cmd(CMD_PUSH_ELEM, 0, 32'h5a5a_5a5a);
      queue_cmd(CMD_PUSH_ELEM, 0, 32'h8000_0000);
      queue_cmd(CMD_PUSH_ELEM, 0, 32'h7fff_ffff);
      queue_cmd(CMD_POP, 0, '0);
      queue_cmd(CMD_POP, 2, '0);
      queue_cmd(CMD_PUSH_BEGIN, 2, '0);
      repeat (4) queue_cmd(CMD_PUSH_ELEM, 0, $urandom);
      queue_cmd(CMD_POP, 3, '0);                      // reads across the wrap
      queue_cmd(CMD_POP, 1, '0);

      run_phase(4'd1, 9'd256, 70, 1'b1);
      run_phase(4'd8, 9'd256, 70, 1'b0);
      run_phase(4'd15, 9'd511, 50, 1'b0);
      run_phase(4'd0, 9'd0, 40, 1'b0);
      run_phase(4'd3, 9'd5, 60, 1'b0);
      run_phase(4'd8, 9'd1, 30, 1'b0);
      run_phase(4'($urandom_range(8, 1)), 9'($urandom_range(40, 1)), 70, 1'b0);
      run_phase(4'd2, 9'd256, 60, 1'b0);

      wait_drained();
      // give a stray late word the chance to show up
      repeat (20) @(posedge clock);
      @(negedge clock);
      while (awaited_results.size() != 0)
         report_mismatch({"never received: ", show_result(awaited_results.pop_front())});
      $display("%0d commands taken, %0d result words checked, %0d register writes",
               items_sent, results_seen, settings_used);
      if (mismatches == 0) $display("multichannel_burst_ring_fifo_core_tb OK");
      else $display("multichannel_burst_ring_fifo_core_tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #(100_000_000);
      $display("multichannel_burst_ring_fifo_core_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
design/mbrf_pkg.sv
design/mbrf_store.sv
design/multichannel_burst_ring_fifo_core.sv
design/mbrf_checker.sv
verif/multichannel_burst_ring_fifo_core_tb.sv
